// ===== rtl/dcc_pkg.sv =====
// dcc_pkg: shared types and constants of the dependency cycle checker
// used by dcc_ram and dependency_cycle_check_top; depends on nothing

package dcc_pkg;

  // fixed field widths
  localparam int TASK_W    = 8;
  localparam int CFG_W     = 9;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 3;

  // default sizes of the stores
  localparam int DEF_MAX_NODES = 256;
  localparam int DEF_MAX_EDGES = 1024;

  // node_count reset value
  localparam logic [CFG_W-1:0] NODE_COUNT_RST = 9'd1;

  // register index taken from paddr[APB_AW-1:2]
  localparam logic [APB_AW-3:0] REG_NODE_COUNT = 1'b0;

  // control sequencer
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_DRAIN,
    S_POP,
    S_POP_WAIT,
    S_EDGES,
    S_RESULT
  } state_t;

  // in-degree read-modify-write operations
  typedef enum logic [1:0] {
    OP_INC,
    OP_DEC,
    OP_CHK
  } op_t;

endpackage

// ===== rtl/dependency_cycle_check_top.sv =====
// dependency_cycle_check_top: cycle check of a task graph by topological sort
// depends on dcc_pkg and dcc_ram (edge store, in-degree table, ready queue)
//
// Usage. Items arrive on the item channel (item_valid / item_stall), one
// prerequisite pair each when edge_valid is set. The block takes one item per
// cycle while it is idle: the pair is written to the edge store and the
// dependent task's in-degree is raised by a read-modify-write on the in-degree
// memory, with a forwarding register covering back-to-back hits on one task.
// The item with last set starts evaluation and item_stall stays high until it
// is done. In evaluation, every pop scans the whole edge store through the
// single read port of that memory. The answer (possible, bad_input) goes out
// on the result channel (result_valid / result_stall) and is held while
// result_stall is high; the sequencer waits in its result state if an older
// answer is still pending. After each answer, and after reset, the in-degree
// memory is swept to zero at one entry per cycle, with item_stall high.
// node_count is written through the APB port, which is always ready.

module dependency_cycle_check_top #(
  parameter int MAX_NODES = dcc_pkg::DEF_MAX_NODES,
  parameter int MAX_EDGES = dcc_pkg::DEF_MAX_EDGES
) (
  input  logic                        clk,
  input  logic                        rst,
  // item channel
  input  logic                        item_valid,
  output logic                        item_stall,
  input  logic                        edge_valid,
  input  logic [dcc_pkg::TASK_W-1:0]  dependent_task,
  input  logic [dcc_pkg::TASK_W-1:0]  prerequisite_task,
  input  logic                        last,
  // result channel
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic                        possible,
  output logic                        bad_input,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dcc_pkg::APB_AW-1:0]  paddr,
  input  logic [dcc_pkg::APB_DW-1:0]  pwdata,
  output logic [dcc_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  localparam int TW     = dcc_pkg::TASK_W;
  localparam int NIW    = $clog2(MAX_NODES);
  localparam int NCW    = $clog2(MAX_NODES + 1);
  localparam int EAW    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EW     = $clog2(MAX_EDGES + 1);
  localparam int EDGE_W = 2 * TW;

  dcc_pkg::state_t state, state_next;

  logic [dcc_pkg::CFG_W-1:0] node_count;
  logic [NCW-1:0]            n;

  logic [EW-1:0]  edge_count;
  logic           error_flag;
  logic [TW-1:0]  max_idx;
  logic           bad;

  logic [NCW-1:0] head, tail, scan_i;
  logic [EW-1:0]  edge_i;
  logic [NIW-1:0] clr_i;
  logic [NIW-1:0] cur;

  // rmw pipeline
  logic           e_v;
  logic           d_v;
  dcc_pkg::op_t   d_op;
  logic [NIW-1:0] d_node;
  logic           lw_v;
  logic [NIW-1:0] lw_addr;
  logic [EW-1:0]  lw_data;

  // memory ports
  logic           ind_we;
  logic [NIW-1:0] ind_waddr, ind_raddr;
  logic [EW-1:0]  ind_wdata, ind_rdata;
  logic              edge_we;
  logic [EAW-1:0]    edge_waddr, edge_raddr;
  logic [EDGE_W-1:0] edge_wdata, edge_rdata;
  logic           q_we;
  logic [NIW-1:0] q_waddr, q_raddr, q_wdata, q_rdata;

  // control decode
  logic item_acc, load_ok, load_bad, ld_go;
  logic scan_issue, edge_issue, res_load, clr_we;
  logic eval_err, e_match;
  logic [TW-1:0]  ld_max;
  logic [NIW-1:0] e_dep;
  logic [NIW-1:0] rd_node;
  dcc_pkg::op_t   rd_op;
  logic           rd_go;
  logic [EW-1:0]  d_cur, d_new;
  logic           d_we, d_push;
  logic           cfg_wr;

  // active node count, capped at the table size
  always_comb begin
    if (32'(node_count) > 32'(MAX_NODES)) begin
      n = NCW'(MAX_NODES);
    end else begin
      n = NCW'(node_count);
    end
  end

  // item checks
  assign item_acc = item_valid && !item_stall;
  assign load_ok  = edge_valid
                    && (32'(dependent_task) < 32'(n))
                    && (32'(prerequisite_task) < 32'(n))
                    && (32'(edge_count) < 32'(MAX_EDGES));
  assign load_bad = edge_valid && !load_ok;
  assign ld_go    = item_acc && load_ok;
  assign ld_max   = (dependent_task > prerequisite_task) ? dependent_task : prerequisite_task;
  assign eval_err = error_flag || ((edge_count != '0) && (32'(max_idx) >= 32'(n)));

  // edge scan stage: does the stored edge leave the current node
  assign e_dep   = NIW'(edge_rdata[EDGE_W-1:TW]);
  assign e_match = e_v && (32'(edge_rdata[TW-1:0]) == 32'(cur));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      dcc_pkg::S_CLEAR: begin
        if (clr_i == NIW'(MAX_NODES - 1)) state_next = dcc_pkg::S_IDLE;
      end
      dcc_pkg::S_IDLE: begin
        if (item_acc && last) state_next = dcc_pkg::S_CHECK;
      end
      dcc_pkg::S_CHECK: begin
        state_next = eval_err ? dcc_pkg::S_RESULT : dcc_pkg::S_SCAN;
      end
      dcc_pkg::S_SCAN: begin
        if (scan_i >= n) state_next = dcc_pkg::S_DRAIN;
      end
      dcc_pkg::S_DRAIN: begin
        if (!e_v && !d_v) state_next = dcc_pkg::S_POP;
      end
      dcc_pkg::S_POP: begin
        state_next = (head != tail) ? dcc_pkg::S_POP_WAIT : dcc_pkg::S_RESULT;
      end
      dcc_pkg::S_POP_WAIT: begin
        state_next = dcc_pkg::S_EDGES;
      end
      dcc_pkg::S_EDGES: begin
        if (edge_i >= edge_count) state_next = dcc_pkg::S_DRAIN;
      end
      dcc_pkg::S_RESULT: begin
        if (!result_valid || !result_stall) state_next = dcc_pkg::S_CLEAR;
      end
      default: state_next = dcc_pkg::S_CLEAR;
    endcase
  end

  // state outputs
  always_comb begin
    item_stall = 1'b1;
    scan_issue = 1'b0;
    edge_issue = 1'b0;
    res_load   = 1'b0;
    clr_we     = 1'b0;
    unique case (state)
      dcc_pkg::S_CLEAR:  clr_we     = 1'b1;
      dcc_pkg::S_IDLE:   item_stall = 1'b0;
      dcc_pkg::S_SCAN:   scan_issue = (scan_i < n);
      dcc_pkg::S_EDGES:  edge_issue = (edge_i < edge_count);
      dcc_pkg::S_RESULT: res_load   = !result_valid || !result_stall;
      dcc_pkg::S_CHECK, dcc_pkg::S_DRAIN, dcc_pkg::S_POP, dcc_pkg::S_POP_WAIT: begin
      end
      default: item_stall = 1'b1;
    endcase
  end

  // in-degree read request: load, initial scan or successor update
  always_comb begin
    rd_go   = 1'b0;
    rd_op   = dcc_pkg::OP_INC;
    rd_node = '0;
    if (ld_go) begin
      rd_go   = 1'b1;
      rd_node = NIW'(dependent_task);
    end else if (scan_issue) begin
      rd_go   = 1'b1;
      rd_op   = dcc_pkg::OP_CHK;
      rd_node = scan_i[NIW-1:0];
    end else if (e_match) begin
      rd_go   = 1'b1;
      rd_op   = dcc_pkg::OP_DEC;
      rd_node = e_dep;
    end
  end
  assign ind_raddr = rd_node;

  // in-degree modify stage, forwarding the latest write
  always_comb begin
    d_cur  = (lw_v && (lw_addr == d_node)) ? lw_data : ind_rdata;
    d_new  = d_cur;
    d_we   = 1'b0;
    d_push = 1'b0;
    case (d_op)
      dcc_pkg::OP_INC: begin
        d_new = d_cur + EW'(1);
        d_we  = d_v;
      end
      dcc_pkg::OP_DEC: begin
        d_new  = d_cur - EW'(1);
        d_we   = d_v && (d_cur != '0);
        d_push = d_v && (d_cur == EW'(1));
      end
      dcc_pkg::OP_CHK: begin
        d_push = d_v && (d_cur == '0);
      end
      default: begin
        d_we = 1'b0;
      end
    endcase
  end

  // in-degree write: clearing sweep or modify stage
  always_comb begin
    if (clr_we) begin
      ind_we    = 1'b1;
      ind_waddr = clr_i;
      ind_wdata = '0;
    end else begin
      ind_we    = d_we;
      ind_waddr = d_node;
      ind_wdata = d_new;
    end
  end

  // edge store and ready queue ports
  assign edge_we    = ld_go;
  assign edge_waddr = edge_count[EAW-1:0];
  assign edge_wdata = {dependent_task, prerequisite_task};
  assign edge_raddr = edge_i[EAW-1:0];
  assign q_we       = d_push;
  assign q_waddr    = tail[NIW-1:0];
  assign q_wdata    = d_node;
  assign q_raddr    = head[NIW-1:0];

  // configuration port
  assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr[dcc_pkg::APB_AW-1:2] == dcc_pkg::REG_NODE_COUNT);
  assign pready = 1'b1;
  always_comb begin
    if (paddr[dcc_pkg::APB_AW-1:2] == dcc_pkg::REG_NODE_COUNT) begin
      prdata = dcc_pkg::APB_DW'(node_count);
    end else begin
      prdata = '0;
    end
  end

  // control and counter registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= dcc_pkg::S_CLEAR;
      node_count   <= dcc_pkg::NODE_COUNT_RST;
      clr_i        <= '0;
      edge_count   <= '0;
      error_flag   <= 1'b0;
      max_idx      <= '0;
      bad          <= 1'b0;
      head         <= '0;
      tail         <= '0;
      scan_i       <= '0;
      edge_i       <= '0;
      e_v          <= 1'b0;
      d_v          <= 1'b0;
      lw_v         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_wr) node_count <= pwdata[dcc_pkg::CFG_W-1:0];

      // clearing sweep
      if (clr_we) begin
        clr_i <= (clr_i == NIW'(MAX_NODES - 1)) ? '0 : clr_i + 1'b1;
      end

      // edge loading
      if (ld_go) begin
        edge_count <= edge_count + 1'b1;
        if (ld_max > max_idx) max_idx <= ld_max;
      end
      if (item_acc && load_bad) error_flag <= 1'b1;

      // evaluation setup
      if (state == dcc_pkg::S_CHECK) begin
        bad    <= eval_err;
        scan_i <= '0;
      end
      if (scan_issue) scan_i <= scan_i + 1'b1;

      // pop a node and restart the edge scan
      if (state == dcc_pkg::S_POP_WAIT) begin
        head   <= head + 1'b1;
        edge_i <= '0;
      end
      if (edge_issue) edge_i <= edge_i + 1'b1;
      e_v <= edge_issue;

      // modify stage and last-write record
      d_v <= rd_go;
      if (ind_we) begin
        lw_v <= 1'b1;
      end
      if (d_push) tail <= tail + 1'b1;

      // answer transfer and problem clear
      if (res_load) begin
        result_valid <= 1'b1;
        edge_count   <= '0;
        error_flag   <= 1'b0;
        max_idx      <= '0;
        head         <= '0;
        tail         <= '0;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == dcc_pkg::S_POP_WAIT) cur <= q_rdata;
    d_op   <= rd_op;
    d_node <= rd_node;
    if (ind_we) begin
      lw_addr <= ind_waddr;
      lw_data <= ind_wdata;
    end
    if (res_load) begin
      possible  <= !bad && (head == n);
      bad_input <= bad;
    end
  end

  // edge store
  dcc_ram #(
    .WIDTH (EDGE_W),
    .DEPTH (MAX_EDGES)
  ) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (edge_waddr),
    .wdata (edge_wdata),
    .raddr (edge_raddr),
    .rdata (edge_rdata)
  );

  // in-degree table
  dcc_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_NODES)
  ) u_indeg_ram (
    .clk   (clk),
    .we    (ind_we),
    .waddr (ind_waddr),
    .wdata (ind_wdata),
    .raddr (ind_raddr),
    .rdata (ind_rdata)
  );

  // ready queue
  dcc_ram #(
    .WIDTH (NIW),
    .DEPTH (MAX_NODES)
  ) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  // queue pointers stay ordered
  a_head_tail: assert property (@(posedge clk) disable iff (rst) head <= tail)
    else $error("ready queue head passed tail");

  // no more nodes queued than exist
  a_tail_bound: assert property (@(posedge clk) disable iff (rst)
    (state == dcc_pkg::S_POP) |-> (tail <= n))
    else $error("ready queue holds more nodes than node_count");

  // an answer appears only from the result state
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(state) == dcc_pkg::S_RESULT))
    else $error("result raised outside the result state");

  // no in-degree update overlaps the clearing sweep
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == dcc_pkg::S_CLEAR) |-> !d_v)
    else $error("in-degree update during clearing sweep");

endmodule

// ===== rtl/dcc_ram.sv =====
// dcc_ram: generic single write port, single read port ram with registered read
// depends on dcc_pkg for default sizes

module dcc_ram #(
  parameter int WIDTH = dcc_pkg::TASK_W,
  parameter int DEPTH = dcc_pkg::DEF_MAX_NODES,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, and read returning the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
